[hdl/d2i_pkg.sv]
// package: rounding mode codes, register addresses and constants for the double to int32 converter
package d2i_pkg;
  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_PLUS    = 2'd2,
    RM_MINUS   = 2'd3
  } rmode_e;

  localparam logic [0:0] ADDR_RMODE = 1'b0;
  localparam logic [0:0] ADDR_INVEN = 1'b1;

  localparam logic [31:0] INT_MAX_VAL = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] HIGH_WORD   = 32'hfff8_0000;

  typedef struct packed {
    logic        write_enable;
    logic        invalid_snan;
    logic        invalid_convert;
    logic        inexact;
    logic        rounded_up;
  } flags_t;
endpackage

[hdl/d2i_core.sv]
// combinational conversion of one double to int32 with rounding, saturation and flags
module d2i_core import d2i_pkg::*; (
  input  logic [63:0] operand_i,
  input  rmode_e      mode_i,
  input  logic        inv_en_i,
  output logic [63:0] result_o,
  output flags_t      flags_o
);
  logic        neg, is_nan, too_big, exc, inc, inx;
  logic [10:0] ex;
  logic [52:0] m;
  logic [5:0]  sh;
  logic        far;
  logic [32:0] ip;
  logic [33:0] mag;
  logic [52:0] rem_mask, rem, half;
  logic [31:0] value;

  always_comb begin
    neg    = operand_i[63];
    ex     = operand_i[62:52];
    is_nan = (ex == 11'h7ff) && (operand_i[51:0] != '0);
    too_big = ex >= 11'd1055;
    m      = {(ex != '0), operand_i[51:0]};
    // shift counts above 52 leave no integer part
    far    = (ex < 11'd1023);
    sh     = far ? 6'd53 : 6'(11'd1075 - ex);
    ip     = far ? '0 : 33'(m >> sh);
    rem_mask = far ? '1 : ((53'd1 << sh) - 53'd1);
    rem    = m & rem_mask;
    half   = (far || sh == 6'd0) ? '0 : (53'd1 << (sh - 6'd1));
    inx    = (ex != '0 || operand_i[51:0] != '0) && (rem != '0);
    case (mode_i)
      RM_NEAREST: inc = !far && ((rem > half) || (rem == half && ip[0]))
                        || (far && ex == 11'd1022 && operand_i[51:0] != '0);
      RM_ZERO:    inc = 1'b0;
      RM_PLUS:    inc = inx && !neg;
      RM_MINUS:   inc = inx && neg;
      default:    inc = 1'b0;
    endcase
    mag = {1'b0, ip} + {33'd0, inc};
    if (is_nan) begin
      value = INT_MIN_VAL;
      exc   = 1'b1;
    end else if (too_big || (!neg && mag > 34'h7fff_ffff) || (neg && mag > 34'h8000_0000)) begin
      value = neg ? INT_MIN_VAL : INT_MAX_VAL;
      exc   = 1'b1;
    end else begin
      value = neg ? (32'd0 - mag[31:0]) : mag[31:0];
      exc   = 1'b0;
    end
    flags_o.write_enable    = !exc || !inv_en_i;
    flags_o.invalid_snan    = is_nan && !operand_i[51];
    flags_o.invalid_convert = exc;
    flags_o.inexact         = inx && !exc;
    flags_o.rounded_up      = inc && !exc;
    result_o = flags_o.write_enable ?
               {HIGH_WORD[31:1], (value == '0) && neg, value} : '0;
  end
endmodule

[hdl/double_to_int32_convert.sv]
// top level: config registers, input register, conversion logic and result register
// the result strobe follows start through two registers: the input register, then the result register
// throughput: one item per cycle; busy is always low
// reset: rounding mode nearest, invalid enable off, no result pending
// the receiver cannot stall, so results are shown for exactly one cycle
module double_to_int32_convert import d2i_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:2]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] operand_bits_i,
  input  logic        truncate_i,
  output logic        result_valid_o,
  output logic [63:0] result_bits_o,
  output logic        write_enable_o,
  output logic        invalid_snan_o,
  output logic        invalid_convert_o,
  output logic        inexact_o,
  output logic        rounded_up_o
);
  rmode_e      rmode_q;
  logic        inv_en_q;
  logic        in_vld_q, out_vld_q;
  logic [63:0] op_q, res_q, res_d;
  logic        trunc_q;
  flags_t      flags_q, flags_d;
  rmode_e      mode;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  // register read mux
  assign prdata = (paddr[2] == ADDR_INVEN) ? {31'd0, inv_en_q} : {30'd0, rmode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmode_q   <= RM_NEAREST;
      inv_en_q  <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == ADDR_RMODE) rmode_q <= rmode_e'(pwdata[1:0]);
        else inv_en_q <= pwdata[0];
      end
      in_vld_q  <= start;
      out_vld_q <= in_vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= operand_bits_i;
    trunc_q <= truncate_i;
    res_q   <= res_d;
    flags_q <= flags_d;
  end

  // truncate overrides the configured mode
  assign mode = trunc_q ? RM_ZERO : rmode_q;

  d2i_core u_core (
    .operand_i(op_q),
    .mode_i   (mode),
    .inv_en_i (inv_en_q),
    .result_o (res_d),
    .flags_o  (flags_d)
  );

  assign result_valid_o    = out_vld_q;
  assign result_bits_o     = res_q;
  assign write_enable_o    = flags_q.write_enable;
  assign invalid_snan_o    = flags_q.invalid_snan;
  assign invalid_convert_o = flags_q.invalid_convert;
  assign inexact_o         = flags_q.inexact;
  assign rounded_up_o      = flags_q.rounded_up;
endmodule

[verif/tb_double_to_int32_convert.sv]
// testbench for the double to int32 converter: random and directed items checked against a predictor
`timescale 1ns / 1ps
module tb_double_to_int32_convert;
  import d2i_pkg::*;

  // one conversion request
  typedef struct {
    logic [63:0] operand;
    logic        trunc;
  } conv_item_t;

  // one converted word with its flags
  typedef struct {
    logic [63:0] word;
    logic        we;
    logic        snan;
    logic        invalid;
    logic        inexact;
    logic        up;
  } conv_result_t;

  localparam int STALL_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [63:0] operand_bits_i;
  logic        truncate_i;
  logic        result_valid_o;
  logic [63:0] result_bits_o;
  logic        write_enable_o, invalid_snan_o, invalid_convert_o, inexact_o, rounded_up_o;

  double_to_int32_convert u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .operand_bits_i, .truncate_i, .result_valid_o, .result_bits_o,
    .write_enable_o, .invalid_snan_o, .invalid_convert_o, .inexact_o, .rounded_up_o
  );

  // predictor's copy of the configuration
  rmode_e      cur_mode;
  logic        cur_inv_en;

  conv_item_t   pending_items[$];
  conv_result_t expected_words[$];
  int           idle_pct;
  int           fail_count;
  int           stall_cycles;
  int           items_sent;
  int           words_checked;
  logic         reset_done;

  // rounds the operand exactly, checks range, builds the destination word
  function automatic conv_result_t convert_double(logic [63:0] bits, logic trunc,
                                                  rmode_e rmode, logic inv_en);
    conv_result_t r;
    rmode_e       mode;
    logic         neg;
    logic [10:0]  ex;
    logic [51:0]  frac;
    logic [31:0]  value;
    logic         exc, snan, inx, up, inc;
    logic [63:0]  m, ip, rem, half, mag;
    int           sh;
    mode  = trunc ? RM_ZERO : rmode;
    neg   = bits[63];
    ex    = bits[62:52];
    frac  = bits[51:0];
    value = '0;
    exc = 0; snan = 0; inx = 0; up = 0; inc = 0;
    if (ex == 11'h7ff && frac != 0) begin
      // nan, signaling when the quiet bit is clear
      snan  = !frac[51];
      value = INT_MIN_VAL;
      exc   = 1;
    end else begin
      if (ex >= 11'd1055) begin
        exc = 1;
      end else begin
        m  = (ex != 0) ? {11'd0, 1'b1, frac} : {12'd0, frac};
        sh = 1075 - ((ex != 0) ? int'(ex) : 1);
        if (sh >= 64) begin
          ip = 0; rem = m; half = '1;
        end else begin
          ip   = m >> sh;
          rem  = m & ((64'd1 << sh) - 64'd1);
          half = 64'd1 << (sh - 1);
        end
        case (mode)
          RM_NEAREST: inc = (rem > half) || (rem == half && ip[0]);
          RM_ZERO:    inc = 0;
          RM_PLUS:    inc = (rem != 0) && !neg;
          default:    inc = (rem != 0) && neg;
        endcase
        mag = ip + (inc ? 64'd1 : 64'd0);
        inx = rem != 0;
        up  = inc;
        if ((!neg && mag > 64'h7fff_ffff) || (neg && mag > 64'h8000_0000)) exc = 1;
        else value = neg ? 32'd0 - mag[31:0] : mag[31:0];
      end
      if (exc) value = neg ? INT_MIN_VAL : INT_MAX_VAL;
    end
    if (exc) begin
      inx = 0; up = 0;
    end
    r.we   = !exc || !inv_en;
    r.word = '0;
    if (r.we) begin
      r.word = {HIGH_WORD, value};
      // negative zero keeps its sign in bit 32
      if (value == 0 && neg) r.word[32] = 1'b1;
    end
    r.snan = snan; r.invalid = exc; r.inexact = inx; r.up = up;
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // driver: pops the next pending item when the sender is not idling
  always @(posedge clk_i) begin
    if (reset_done) begin
      if (start && !busy) begin
        expected_words.push_back(convert_double(operand_bits_i, truncate_i,
                                                cur_mode, cur_inv_en));
        items_sent <= items_sent + 1;
      end
      if ((!start || !busy) && pending_items.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        conv_item_t it;
        it = pending_items.pop_front();
        start          <= 1'b1;
        operand_bits_i <= it.operand;
        truncate_i     <= it.trunc;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobe is compared with the oldest expectation
  always @(posedge clk_i) begin
    if (reset_done) begin
      if (result_valid_o) begin
        stall_cycles <= 0;
        if (expected_words.size() == 0) begin
          $error("result with no item outstanding: %h", result_bits_o);
          fail_count++;
        end else begin
          conv_result_t e;
          e = expected_words.pop_front();
          if (result_bits_o !== e.word) begin
            $error("result_bits exp %h got %h", e.word, result_bits_o); fail_count++;
          end
          if (write_enable_o !== e.we) begin
            $error("write_enable exp %b got %b", e.we, write_enable_o); fail_count++;
          end
          if (invalid_snan_o !== e.snan) begin
            $error("invalid_snan exp %b got %b", e.snan, invalid_snan_o); fail_count++;
          end
          if (invalid_convert_o !== e.invalid) begin
            $error("invalid_convert exp %b got %b", e.invalid, invalid_convert_o);
            fail_count++;
          end
          if (inexact_o !== e.inexact) begin
            $error("inexact exp %b got %b", e.inexact, inexact_o); fail_count++;
          end
          if (rounded_up_o !== e.up) begin
            $error("rounded_up exp %b got %b", e.up, rounded_up_o); fail_count++;
          end
          words_checked <= words_checked + 1;
        end
      end else if (start && !busy) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // watchdog on cycles with no accepted item and no result
  always @(posedge clk_i) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_words.size());
      $display("FAIL");
      $finish;
    end
  end

  // register write over the apb port, only while nothing is in flight
  task automatic write_reg(logic [2:2] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_RMODE) cur_mode = rmode_e'(data[1:0]);
    else cur_inv_en = data[0];
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_item(logic [63:0] op, logic tr);
    conv_item_t it;
    it.operand = op;
    it.trunc   = tr;
    pending_items.push_back(it);
  endtask

  // random operand biased toward exponents that land near the int32 range
  function automatic logic [63:0] rand_operand();
    logic [63:0] b;
    int          k;
    b = {$urandom, $urandom};
    k = $urandom_range(9);
    if (k < 6) b[62:52] = 11'd1023 + 11'($urandom_range(34)) - 11'd2;
    else if (k == 6) b[62:52] = 11'd1022 + 11'($urandom_range(1));
    else if (k == 7) begin
      // exact halves and small fractions
      b[62:52] = 11'd1023 + 11'($urandom_range(30));
      b[51:0]  = b[51:0] & ~(52'hf_ffff_ffff_ffff >> $urandom_range(31));
    end else if (k == 8) b[62:52] = $urandom_range(1) ? 11'h7ff : 11'h000;
    return b;
  endfunction

  initial begin
    rst_ni = 0; reset_done = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    start = 0; operand_bits_i = '0; truncate_i = 0;
    cur_mode = RM_NEAREST; cur_inv_en = 0;
    idle_pct = 37; fail_count = 0; stall_cycles = 0;
    items_sent = 0; words_checked = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    reset_done <= 1;

    // directed: zeros, halves, range edges, infinities, nans, denormals
    add_item(64'h0000_0000_0000_0000, 0);
    add_item(64'h8000_0000_0000_0000, 0);
    add_item(64'h3fe0_0000_0000_0000, 0);   // 0.5 tie to even
    add_item(64'h3ff8_0000_0000_0000, 0);   // 1.5
    add_item(64'h4004_0000_0000_0000, 0);   // 2.5
    add_item(64'hbff8_0000_0000_0000, 0);   // -1.5
    add_item(64'h41df_ffff_ffc0_0000, 0);   // int max
    add_item(64'h41df_ffff_ffe0_0000, 0);   // int max + 0.5
    add_item(64'hc1e0_0000_0000_0000, 0);   // int min
    add_item(64'hc1e0_0000_0010_0000, 0);   // below int min
    add_item(64'h41e0_0000_0000_0000, 0);
    add_item(64'h7ff0_0000_0000_0000, 0);
    add_item(64'hfff0_0000_0000_0000, 0);
    add_item(64'h7ff8_0000_0000_0001, 0);   // quiet nan
    add_item(64'h7ff0_0000_0000_0001, 1);   // signaling nan
    add_item(64'hffff_ffff_ffff_ffff, 0);
    add_item(64'h0000_0000_0000_0001, 0);   // smallest denormal
    add_item(64'h800f_ffff_ffff_ffff, 0);
    add_item(64'hbfe8_0000_0000_0000, 1);
    add_item(64'h7fef_ffff_ffff_ffff, 0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ADDR_RMODE, {30'd0, 2'(ph % 4)});
      write_reg(ADDR_INVEN, {31'd0, 1'(ph / 4)});
      idle_pct = (ph < 3) ? 37 : (ph < 6) ? 72 : 0;
      for (int i = 0; i < 145; i++) add_item(rand_operand(), $urandom_range(3) == 0);
      wait_drained();
    end

    $display("checked %0d results over %0d items, all rounding modes, both enable settings",
             words_checked, items_sent);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

[double_to_int32_convert.f]
hdl/d2i_pkg.sv
hdl/d2i_core.sv
hdl/double_to_int32_convert.sv
verif/tb_double_to_int32_convert.sv
